@@ hdl/rrt_pkg.sv @@
`timescale 1ns / 1ps

package rrt_pkg;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_SAMPLE_STEP = 2'd0;
	localparam logic [1:0] REG_RATE_LOW    = 2'd1;
	localparam logic [1:0] REG_RATE_HIGH   = 2'd2;

	// Reset values of the configuration registers
	localparam logic [11:0] STEP_RESET = 12'd250;
	localparam logic [7:0]  LOW_RESET  = 8'd40;
	localparam logic [7:0]  HIGH_RESET = 8'd200;

	// Milliseconds per minute, and the same scaled by 256 for Q8.8 output
	localparam logic [23:0] MS_PER_MIN    = 24'd60000;
	localparam logic [23:0] MS_PER_MIN_Q8 = 24'd15360000;

	localparam logic [15:0] RATE_MAX = 16'hFFFF;

	// Divider iteration counts for each use
	localparam logic [5:0] ITER_RATE   = 6'd24;
	localparam logic [5:0] ITER_INTERP = 6'd16;
	localparam logic [5:0] ITER_MOD    = 6'd32;

	typedef enum logic [1:0] {
		DIV_RATE,
		DIV_INTERP,
		DIV_MOD
	} div_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BAND,
		ST_RATE_WAIT,
		ST_CHECK,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT,
		ST_MOD_GO,
		ST_MOD_WAIT
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic    load;         // take a beat interval, advance the beat clock
		logic    div_start;    // launch the shared divider
		div_op_t div_op;       // which division to launch
		logic    setup;        // latch beat rate, span, offset, clear count
		logic    mul;          // register rate difference times offset
		logic    take_beat;    // sample sits on the beat: take its rate
		logic    take_interp;  // take the interpolated rate
		logic    emit;         // load the output register, advance the grid
		logic    fin_norm;     // close the beat, grid continues from offset
		logic    fin_mod;      // close the beat, grid jumps past the beat
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic drop;       // beat rate outside the band
		logic off_gt;     // next grid point lies after the beat
		logic off_eq;     // next grid point lies on the beat
		logic div_done;   // divider finished this cycle
		logic out_free;   // output register can take a sample
		logic emit_ovf;   // sample being emitted hits the cap before the beat
	} stat_t;

endpackage

@@ hdl/rrt_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
// The partial remainder starts at r0 and numerator bits shift in from the
// top of n0; quotient bits collect at the bottom of quo.
module rrt_div import rrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] r0,
	input  logic [47:0] n0,
	input  logic [31:0] d,
	input  logic [5:0]  iters,
	output logic        done,
	output logic [47:0] quo,
	output logic [31:0] rem
);

	logic [31:0] r_q;
	logic [47:0] n_q;
	logic [31:0] d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [32:0] trial;
	logic        ge;
	logic [32:0] r_next;

	// Shift one bit in, subtract when it fits
	assign trial  = {r_q, n_q[47]};
	assign ge     = trial >= {1'b0, d_q};
	assign r_next = ge ? (trial - {1'b0, d_q}) : trial;

	// Control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and numerator/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= r0;
			n_q <= n0;
			d_q <= d;
		end else if (busy_q) begin
			r_q <= r_next[31:0];
			n_q <= {n_q[46:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = n_q;
	assign rem  = r_q;

endmodule

@@ hdl/rrt_dpath.sv @@
`timescale 1ns / 1ps

module rrt_dpath import rrt_pkg::*; #(
	parameter int MAX_SAMPLES_PER_BEAT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic [15:0] rr_ms,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_time,
	output logic [15:0] out_rate,
	output logic        out_last,
	output logic        out_ovf
);

	localparam int CW = $clog2(MAX_SAMPLES_PER_BEAT + 1);
	localparam logic [CW-1:0] CAP = CW'(MAX_SAMPLES_PER_BEAT);

	// Configuration
	logic [11:0] step_q;
	logic [7:0]  rate_low_q;
	logic [7:0]  rate_high_q;

	// Beat and grid state
	logic [31:0] beat_clock_q;
	logic [31:0] prev_time_q;
	logic [15:0] prev_rate_q;
	logic [31:0] next_time_q;
	logic        seen_q;

	// Working registers of one beat
	logic [15:0]   rr_q;
	logic [15:0]   yb_q;
	logic [31:0]   span_q;
	logic [32:0]   off_q;
	logic [CW-1:0] cnt_q;
	logic [47:0]   prod_q;
	logic [15:0]   rate_q;

	// Output register
	logic        out_valid_q;
	logic [31:0] out_time_q;
	logic [15:0] out_rate_q;
	logic        out_last_q;
	logic        out_ovf_q;

	logic [11:0]   step_eff;
	logic [23:0]   lo_prod;
	logic [23:0]   hi_prod;
	logic [23:0]   rate_num;
	logic          up;
	logic [15:0]   diff;
	logic [47:0]   interp_num;
	logic [32:0]   off_next;
	logic [CW-1:0] cnt_next;
	logic          cap_hit;
	logic          past_beat;
	logic [31:0]   mod_arg;

	logic        div_start;
	logic [31:0] div_r0;
	logic [47:0] div_n0;
	logic [31:0] div_d;
	logic [5:0]  div_iters;
	logic        div_done;
	logic [47:0] div_quo;
	logic [31:0] div_rem;

	assign step_eff = (step_q == 12'd0) ? 12'd1 : step_q;

	// Band test, exact: rate_low*rr <= 60000 <= rate_high*rr
	assign lo_prod = {16'd0, rate_low_q} * {8'd0, rr_q};
	assign hi_prod = {16'd0, rate_high_q} * {8'd0, rr_q};

	// Rounded beat rate numerator
	assign rate_num = MS_PER_MIN_Q8 + {9'd0, rr_q[15:1]};

	// Interpolation terms
	assign up         = yb_q >= prev_rate_q;
	assign diff       = up ? (yb_q - prev_rate_q) : (prev_rate_q - yb_q);
	assign interp_num = prod_q + {17'd0, span_q[31:1]};

	// Grid advance and per-beat cap
	assign off_next  = off_q + {21'd0, step_eff};
	assign cnt_next  = cnt_q + 1'b1;
	assign cap_hit   = cnt_next == CAP;
	assign past_beat = off_next > {1'b0, span_q};
	assign mod_arg   = span_q - off_q[31:0];

	// Operand select of the shared divider
	assign div_start = cmd.div_start;
	always_comb begin
		div_r0    = 32'd0;
		div_n0    = {rate_num, 24'd0};
		div_d     = {16'd0, rr_q};
		div_iters = ITER_RATE;
		case (cmd.div_op)
			DIV_RATE: begin
				div_r0    = 32'd0;
				div_n0    = {rate_num, 24'd0};
				div_d     = {16'd0, rr_q};
				div_iters = ITER_RATE;
			end
			DIV_INTERP: begin
				div_r0    = interp_num[47:16];
				div_n0    = {interp_num[15:0], 32'd0};
				div_d     = span_q;
				div_iters = ITER_INTERP;
			end
			DIV_MOD: begin
				div_r0    = 32'd0;
				div_n0    = {mod_arg, 16'd0};
				div_d     = {20'd0, step_eff};
				div_iters = ITER_MOD;
			end
			default: begin
				div_r0    = 32'd0;
				div_n0    = {rate_num, 24'd0};
				div_d     = {16'd0, rr_q};
				div_iters = ITER_RATE;
			end
		endcase
	end

	rrt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.r0     (div_r0),
		.n0     (div_n0),
		.d      (div_d),
		.iters  (div_iters),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_RESET;
			rate_low_q  <= LOW_RESET;
			rate_high_q <= HIGH_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SAMPLE_STEP: step_q      <= cfg_data;
				REG_RATE_LOW:    rate_low_q  <= cfg_data[7:0];
				REG_RATE_HIGH:   rate_high_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Beat clock and kept point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_clock_q <= '0;
			prev_time_q  <= '0;
			prev_rate_q  <= '0;
			next_time_q  <= '0;
			seen_q       <= 1'b0;
		end else begin
			if (cmd.load) begin
				beat_clock_q <= seen_q ? (beat_clock_q + {16'd0, rr_ms}) : 32'd0;
				seen_q       <= 1'b1;
			end
			if (cmd.fin_norm) begin
				next_time_q <= prev_time_q + off_q[31:0];
				prev_time_q <= beat_clock_q;
				prev_rate_q <= yb_q;
			end
			if (cmd.fin_mod) begin
				next_time_q <= beat_clock_q + {20'd0, step_eff} - {20'd0, div_rem[11:0]};
				prev_time_q <= beat_clock_q;
				prev_rate_q <= yb_q;
			end
		end
	end

	// Working registers of the current beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rr_q <= rr_ms;
		end
		if (cmd.setup) begin
			yb_q   <= (div_quo[23:16] != 8'd0) ? RATE_MAX : div_quo[15:0];
			span_q <= beat_clock_q - prev_time_q;
			off_q  <= {1'b0, next_time_q - prev_time_q};
		end
		if (cmd.mul) begin
			prod_q <= {16'd0, diff} * {16'd0, off_q[31:0]};
		end
		if (cmd.take_beat) begin
			rate_q <= yb_q;
		end
		if (cmd.take_interp) begin
			rate_q <= up ? (prev_rate_q + div_quo[15:0]) : (prev_rate_q - div_quo[15:0]);
		end
		if (cmd.emit) begin
			off_q <= off_next;
		end
	end

	// Sample count of the current beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.setup) begin
			cnt_q <= '0;
		end else if (cmd.emit) begin
			cnt_q <= cnt_next;
		end
	end

	// Output register: hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_time_q <= prev_time_q + off_q[31:0];
			out_rate_q <= rate_q;
			out_last_q <= past_beat || cap_hit;
			out_ovf_q  <= cap_hit && !past_beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_time  = out_time_q;
	assign out_rate  = out_rate_q;
	assign out_last  = out_last_q;
	assign out_ovf   = out_ovf_q;

	assign stat.drop     = (lo_prod > MS_PER_MIN) || (hi_prod < MS_PER_MIN);
	assign stat.off_gt   = off_q > {1'b0, span_q};
	assign stat.off_eq   = off_q == {1'b0, span_q};
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.emit_ovf = cap_hit && !past_beat;

endmodule

@@ hdl/rrt_ctrl.sv @@
`timescale 1ns / 1ps

module rrt_ctrl import rrt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.div_op = DIV_RATE;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_BAND;
				end
			end
			ST_BAND: begin
				if (stat.drop) begin
					state_d = ST_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_op    = DIV_RATE;
					state_d       = ST_RATE_WAIT;
				end
			end
			ST_RATE_WAIT: begin
				if (stat.div_done) begin
					cmd.setup = 1'b1;
					state_d   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.off_gt) begin
					cmd.fin_norm = 1'b1;
					state_d      = ST_IDLE;
				end else if (stat.off_eq) begin
					cmd.take_beat = 1'b1;
					state_d       = ST_EMIT;
				end else begin
					cmd.mul = 1'b1;
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_INTERP;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				cmd.div_op = DIV_INTERP;
				if (stat.div_done) begin
					cmd.take_interp = 1'b1;
					state_d         = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = stat.emit_ovf ? ST_MOD_GO : ST_CHECK;
				end
			end
			ST_MOD_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_MOD;
				state_d       = ST_MOD_WAIT;
			end
			ST_MOD_WAIT: begin
				cmd.div_op = DIV_MOD;
				if (stat.div_done) begin
					cmd.fin_mod = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/rr_tachogram_resampler.sv @@
`timescale 1ns / 1ps

// RR tachogram resampler. Each input transfer carries one RR interval in ms
// that advances a 32-bit beat clock (the first beat sits at time 0). The beat
// rate, round(15360000/rr) in Q8.8 bpm, is checked against the configured bpm
// band; a beat outside it is dropped while the clock still advances. For a
// kept beat the block emits rate samples on a grid of sample_step_ms, linearly
// interpolated from the previous kept point (initially time 0, rate 0) up to
// the beat, at most MAX_SAMPLES_PER_BEAT per beat; the final one carries tlast,
// and tuser marks that further grid points were skipped, after which the grid
// jumps to its first point past the beat. One beat is worked on at a time,
// using a single bit-serial divider: the band test and the rate division, then
// for each interpolated sample a multiply and a division in the divider, while a
// sample that lands on the beat needs no division, and last the beat is closed,
// with a modulo division first when the cap is hit. A dropped beat returns to
// idle after the band test. Output backpressure adds stall cycles; the next
// interval is taken while the last sample still waits in the output register.
// Write configuration only while the block is idle.
module rr_tachogram_resampler import rrt_pkg::*; #(
	parameter int MAX_SAMPLES_PER_BEAT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] rr_ms
	// Output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [31:0] sample_time_ms, [47:32] rate_q8
	output logic        m_axis_tlast,
	output logic        m_axis_tuser,   // [0] overflow
	// Configuration writes
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	cmd_t        cmd;
	stat_t       stat;
	logic [31:0] out_time;
	logic [15:0] out_rate;

	rrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rrt_dpath #(
		.MAX_SAMPLES_PER_BEAT (MAX_SAMPLES_PER_BEAT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.rr_ms     (s_axis_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_time  (out_time),
		.out_rate  (out_rate),
		.out_last  (m_axis_tlast),
		.out_ovf   (m_axis_tuser)
	);

	assign m_axis_tdata = {out_rate, out_time};

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import rrt_pkg::*;

	localparam int MAX_PER_BEAT     = 64;
	localparam int SETTLE_CYCLES    = 200;
	localparam int CYCLE_LIMIT      = 6000000;
	localparam int MAX_REPORTS      = 10;
	localparam int RANDOM_PER_PHASE = 112;

	typedef struct packed {
		logic [31:0] time_ms;
		logic [15:0] rate_q8;
		logic        last;
		logic        overflow;
	} rate_sample_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;   // [15:0] rr_ms
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;         // [31:0] sample_time_ms, [47:32] rate_q8
	logic        m_axis_tlast;
	logic        m_axis_tuser;         // [0] overflow
	logic        cfg_wr_en     = 1'b0;
	logic [1:0]  cfg_index     = REG_SAMPLE_STEP;
	logic [11:0] cfg_data      = '0;

	// Resampler model state and its copy of the registers
	logic [11:0] step_ms        = STEP_RESET;
	logic [7:0]  low_bpm        = LOW_RESET;
	logic [7:0]  high_bpm       = HIGH_RESET;
	logic [31:0] beat_clock_ms  = '0;
	logic [31:0] kept_time_ms   = '0;
	logic [15:0] kept_rate_q8   = '0;
	logic [31:0] grid_time_ms   = '0;
	logic        beat_seen      = 1'b0;

	rate_sample_t expected_samples[$];
	int unsigned  predicted_count    = 0;
	int unsigned  mismatch_count     = 0;
	int unsigned  sender_idle_pct    = 0;
	int unsigned  receiver_stall_pct = 0;
	int unsigned  cycle_count        = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rr_tachogram_resampler #(
		.MAX_SAMPLES_PER_BEAT(MAX_PER_BEAT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Beat rate in Q8.8 bpm, halves rounded up, saturated
	function automatic logic [15:0] beat_rate(input logic [15:0] rr);
		longint unsigned r;
		longint unsigned q;
		r = rr;
		q = (64'd15360000 + r / 2) / r;
		return (q > 64'd65535) ? 16'hFFFF : q[15:0];
	endfunction

	// Linear interpolation, change rounded to nearest with halves away from ya
	function automatic logic [15:0] interp_rate(input logic [15:0] ya, input logic [15:0] yb,
			input longint unsigned off, input longint unsigned span);
		longint unsigned diff;
		longint unsigned d;
		if (off >= span || span == 0)
			return yb;
		if (yb >= ya) begin
			diff = yb - ya;
			d = (diff * off + span / 2) / span;
			return ya + d[15:0];
		end
		diff = ya - yb;
		d = (diff * off + span / 2) / span;
		return ya - d[15:0];
	endfunction

	// Advance the beat clock and queue the grid samples this beat produces
	function automatic void resample_beat(input logic [15:0] rr);
		logic [31:0]     beat_ms;
		logic [15:0]     beat_q8;
		logic [31:0]     gap;
		longint unsigned span;
		longint unsigned off;
		longint unsigned stride;
		longint unsigned nxt;
		longint unsigned lo_prod;
		longint unsigned hi_prod;
		int              n;
		rate_sample_t    s;
		stride = (step_ms == 0) ? 1 : step_ms;
		if (beat_seen)
			beat_clock_ms = beat_clock_ms + rr;
		else
			beat_clock_ms = '0;
		beat_seen = 1'b1;
		beat_ms = beat_clock_ms;
		lo_prod = low_bpm * rr;
		hi_prod = high_bpm * rr;
		if (lo_prod > 60000 || hi_prod < 60000)
			return;
		beat_q8 = beat_rate(rr);
		gap = beat_ms - kept_time_ms;
		span = gap;
		gap = grid_time_ms - kept_time_ms;
		off = gap;
		n = 0;
		while (off <= span && n < MAX_PER_BEAT) begin
			nxt = off + stride;
			s.time_ms  = kept_time_ms + off[31:0];
			s.rate_q8  = interp_rate(kept_rate_q8, beat_q8, off, span);
			s.last     = (nxt > span) || (n == MAX_PER_BEAT - 1);
			s.overflow = (n == MAX_PER_BEAT - 1) && (nxt <= span);
			expected_samples = {expected_samples, s};
			n++;
			off = nxt;
		end
		// cap hit: jump the grid to its first point past the beat
		if (n > 0 && off <= span)
			off += ((span - off) / stride + 1) * stride;
		grid_time_ms = kept_time_ms + off[31:0];
		kept_time_ms = beat_ms;
		kept_rate_q8 = beat_q8;
		predicted_count += n;
	endfunction

	// Mostly plausible intervals inside the band, some edges and raw noise
	function automatic logic [15:0] pick_rr();
		int unsigned fast_rr;
		int unsigned slow_rr;
		int unsigned lo;
		int unsigned hi;
		fast_rr = (high_bpm == 0) ? 65535 : (60000 + high_bpm - 1) / high_bpm;
		slow_rr = (low_bpm == 0) ? 65535 : 60000 / low_bpm;
		lo = (fast_rr > 250) ? fast_rr : 250;
		hi = (slow_rr < 2000) ? slow_rr : 2000;
		if (lo > hi) begin
			lo = fast_rr;
			hi = slow_rr;
		end
		case ($urandom_range(19))
			0, 1: return 16'($urandom());
			2: return 16'(fast_rr - 1);
			3: return 16'(fast_rr);
			4: return 16'(slow_rr);
			5: return 16'(slow_rr + 1);
			default: return 16'($urandom_range(hi, lo));
		endcase
	endfunction

	// Offer one interval after a random gap; predict on the transfer
	task automatic send_rr(input logic [15:0] rr);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= rr;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		resample_beat(rr);
	endtask

	// Hold the input until every queued sample is out, then let the block settle
	task automatic wait_all_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers on consecutive edges
	task automatic write_config(input logic [11:0] step_val, input logic [7:0] low_val,
			input logic [7:0] high_val);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_SAMPLE_STEP;
		cfg_data  <= step_val;
		@(posedge clk);
		cfg_index <= REG_RATE_LOW;
		cfg_data  <= {4'd0, low_val};
		@(posedge clk);
		cfg_index <= REG_RATE_HIGH;
		cfg_data  <= {4'd0, high_val};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		step_ms  = step_val;
		low_bpm  = low_val;
		high_bpm = high_val;
	endtask

	task automatic test_directed();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		// reset band: rejected first beat, then kept beats rising from time 0, rate 0
		send_rr(16'd3000);
		send_rr(16'd1000);
		send_rr(16'd300);    // exactly 200 bpm
		send_rr(16'd1500);   // exactly 40 bpm
		send_rr(16'd1501);
		send_rr(16'd299);
		send_rr(16'd0);      // zero interval, clock holds
		send_rr(16'd800);
		// zero step acts as 1 ms: every kept beat overruns the cap
		wait_all_results();
		write_config(12'd0, LOW_RESET, HIGH_RESET);
		send_rr(16'd400);
		send_rr(16'd250);
		// band of 1 to 255 bpm, coarsest grid
		wait_all_results();
		write_config(12'd4095, 8'd1, 8'd255);
		send_rr(16'd60000);
		send_rr(16'd236);
		send_rr(16'd235);
		send_rr(16'hFFFF);
		send_rr(16'd1);
		// one-bpm band with a 1 ms grid
		wait_all_results();
		write_config(12'd1, 8'd1, 8'd1);
		send_rr(16'd60000);
		send_rr(16'd59999);
		// open low edge lets the longest interval through
		wait_all_results();
		write_config(12'd4095, 8'd0, 8'd255);
		send_rr(16'hFFFF);
		send_rr(16'hAAAA);
		send_rr(16'h5555);
		// empty band
		wait_all_results();
		write_config(12'd2048, 8'd255, 8'd255);
		send_rr(16'd236);
		send_rr(16'd235);
	endtask

	task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input logic [11:0] step_val, input logic [7:0] low_val, input logic [7:0] high_val);
		int unsigned sent;
		wait_all_results();
		write_config(step_val, low_val, high_val);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		sent = 0;
		while (sent < RANDOM_PER_PHASE) begin
			send_rr(pick_rr());
			sent++;
			if (sent == RANDOM_PER_PHASE / 2)
				wait_all_results();
		end
	endtask

	// Randomize output backpressure; compare every sample transfer
	always @(posedge clk) begin
		rate_sample_t got;
		rate_sample_t want;
		m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tlast, m_axis_tuser};
			if (expected_samples.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected sample: time %0d rate %0d last %0b overflow %0b",
						got.time_ms, got.rate_q8, got.last, got.overflow);
			end else begin
				want = expected_samples.pop_front();
				if (got.time_ms !== want.time_ms || got.rate_q8 !== want.rate_q8 ||
						got.last !== want.last || got.overflow !== want.overflow) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("sample: expected time %0d rate %0d last %0b overflow %0b, %s",
							want.time_ms, want.rate_q8, want.last, want.overflow,
							$sformatf("got time %0d rate %0d last %0b overflow %0b",
								got.time_ms, got.rate_q8, got.last, got.overflow));
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("rr_tachogram_resampler: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(0, 0, STEP_RESET, LOW_RESET, HIGH_RESET);
		test_random_phase(74, 0, 12'($urandom_range(1000, 100)), 8'($urandom_range(60, 1)),
			8'($urandom_range(255, 150)));
		test_random_phase(0, 74, 12'd4095, 8'd1, 8'd255);
		test_random_phase(23, 23, 12'($urandom_range(60, 20)), 8'($urandom_range(45, 30)),
			8'($urandom_range(220, 180)));
		wait_all_results();
		if (mismatch_count == 0 && expected_samples.size() == 0)
			$display("rr_tachogram_resampler: match");
		else
			$display("rr_tachogram_resampler: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/rrt_pkg.sv
hdl/rrt_div.sv
hdl/rrt_dpath.sv
hdl/rrt_ctrl.sv
hdl/rr_tachogram_resampler.sv
bench/tb.sv
